>>> rtl/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction execute unit.
// No dependencies; used by every module in rtl/.
package c8ie_pkg;

  typedef struct packed {
    logic [15:0] instruction;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic        reg_written;
    logic [3:0]  written_reg;
    logic [7:0]  written_value;
    logic        flag_value;
    logic        clear_screen;
    logic [1:0]  status;
  } out_item_t;

  // Instruction classes produced by the front end
  typedef enum logic [3:0] {
    OP_CLS,
    OP_RET,
    OP_JP,
    OP_CALL,
    OP_SE_K,
    OP_SNE_K,
    OP_SE_V,
    OP_SNE_V,
    OP_LD_K,
    OP_ADD_K,
    OP_ALU,
    OP_LD_I,
    OP_JP_V0,
    OP_RND,
    OP_ILL
  } op_cls_t;

  // 8XYN function codes
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ILL   = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  localparam logic [11:0] START_RESET = 12'h200;
  localparam logic [3:0]  VF_IDX      = 4'hF;
  localparam logic [3:0]  V0_IDX      = 4'h0;

  // Decoded instruction handed from front to back
  typedef struct packed {
    op_cls_t     cls;
    logic [3:0]  fn;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] nnn;
    logic [7:0]  rnd_kk;
  } dec_t;

  typedef struct packed {
    logic       full;
    logic       nonempty;
    logic [1:0] count;
  } q_stat_t;

endpackage

>>> rtl/c8ie_front.sv
// Front end: accepts instruction transactions and classifies them.
// Depends on c8ie_pkg; feeds c8ie_queue.
module c8ie_front (
  input  c8ie_pkg::in_item_t in_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  c8ie_pkg::q_stat_t  q_stat,
  output logic               push,
  output c8ie_pkg::dec_t     dec
);
  import c8ie_pkg::*;

  localparam logic [3:0]  OPC_SYS  = 4'h0;
  localparam logic [3:0]  OPC_JP   = 4'h1;
  localparam logic [3:0]  OPC_CALL = 4'h2;
  localparam logic [3:0]  OPC_SEK  = 4'h3;
  localparam logic [3:0]  OPC_SNEK = 4'h4;
  localparam logic [3:0]  OPC_SEV  = 4'h5;
  localparam logic [3:0]  OPC_LDK  = 4'h6;
  localparam logic [3:0]  OPC_ADDK = 4'h7;
  localparam logic [3:0]  OPC_ALU  = 4'h8;
  localparam logic [3:0]  OPC_SNEV = 4'h9;
  localparam logic [3:0]  OPC_LDI  = 4'hA;
  localparam logic [3:0]  OPC_JPV0 = 4'hB;
  localparam logic [3:0]  OPC_RND  = 4'hC;
  localparam logic [15:0] INS_CLS  = 16'h00E0;
  localparam logic [15:0] INS_RET  = 16'h00EE;
  localparam logic [3:0]  N_ZERO   = 4'h0;

  logic [15:0] ins;
  logic [3:0]  n;

  assign ins      = in_data.instruction;
  assign n        = ins[3:0];
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    dec.fn     = n;
    dec.x      = ins[11:8];
    dec.y      = ins[7:4];
    dec.nnn    = ins[11:0];
    dec.rnd_kk = in_data.random_byte & ins[7:0];
    dec.cls    = OP_ILL;
    unique case (ins[15:12])
      OPC_SYS: begin
        if (ins == INS_CLS) dec.cls = OP_CLS;
        else if (ins == INS_RET) dec.cls = OP_RET;
      end
      OPC_JP:   dec.cls = OP_JP;
      OPC_CALL: dec.cls = OP_CALL;
      OPC_SEK:  dec.cls = OP_SE_K;
      OPC_SNEK: dec.cls = OP_SNE_K;
      OPC_SEV:  if (n == N_ZERO) dec.cls = OP_SE_V;
      OPC_LDK:  dec.cls = OP_LD_K;
      OPC_ADDK: dec.cls = OP_ADD_K;
      OPC_ALU: begin
        if (n == ALU_LD || n == ALU_OR || n == ALU_AND || n == ALU_XOR ||
            n == ALU_ADD || n == ALU_SUB || n == ALU_SHR || n == ALU_SUBN ||
            n == ALU_SHL) dec.cls = OP_ALU;
      end
      OPC_SNEV: if (n == N_ZERO) dec.cls = OP_SNE_V;
      OPC_LDI:  dec.cls = OP_LD_I;
      OPC_JPV0: dec.cls = OP_JP_V0;
      OPC_RND:  dec.cls = OP_RND;
      default:  dec.cls = OP_ILL;
    endcase
  end

endmodule

>>> rtl/c8ie_queue.sv
// Two-entry queue of decoded instructions between front and back.
// Depends on c8ie_pkg.
module c8ie_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  c8ie_pkg::dec_t    push_data,
  input  logic              pop,
  output c8ie_pkg::dec_t    head,
  output c8ie_pkg::q_stat_t q_stat
);
  import c8ie_pkg::*;

  localparam logic [1:0] Q_FULL = 2'd2;

  dec_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  assign head            = slot_r[rp_r];
  assign q_stat.full     = (cnt_r == Q_FULL);
  assign q_stat.nonempty = (cnt_r != 2'd0);
  assign q_stat.count    = cnt_r;

endmodule

>>> rtl/c8ie_back.sv
// Back end: operand read, execute against PC/I/V/stack, result register.
// Depends on c8ie_pkg; pops from c8ie_queue.
module c8ie_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  c8ie_pkg::dec_t      q_head,
  input  c8ie_pkg::q_stat_t   q_stat,
  output logic                q_pop,
  input  logic                cfg_load,
  input  logic [11:0]         cfg_pc,
  output c8ie_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_ready
);
  import c8ie_pkg::*;

  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam logic [LVW-1:0] LVL_FULL = LVW'(STACK_DEPTH);

  // V1..V14 live in vmem; V0 and VF are also kept in flops for BNNN and flags
  logic [7:0]     vmem [16];
  logic [15:0]    vvld_r;
  logic [11:0]    stk  [STACK_DEPTH];

  logic [11:0]    pc_r, pc_nxt;
  logic [11:0]    i_r, i_nxt;
  logic [7:0]     v0_r, v0_nxt;
  logic [7:0]     vf_r, vf_nxt;
  logic [LVW-1:0] lvl_r, lvl_nxt;
  logic [11:0]    tos_r, tos_nxt;
  logic [11:0]    below_r;
  logic [SIW-1:0] rd_addr;

  logic           e_valid_r, e_valid_nxt;
  dec_t           e_r;
  logic [7:0]     xraw_r, yraw_r;
  logic           xvld_r, yvld_r;
  logic           xbyp_r, ybyp_r;
  logic [7:0]     byp_val_r;

  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r;

  logic           retire;
  logic [7:0]     opx, opy;
  logic [11:0]    pc_p2, pc_p4;
  logic [8:0]     sum9;
  logic [11:0]    npc;
  logic           wr, wflag, flag, clr, push, pop_stk, ld_i;
  logic [7:0]     val;
  logic [1:0]     status;

  assign retire = e_valid_r && (!out_valid_r || out_ready);
  assign q_pop  = q_stat.nonempty && (!e_valid_r || retire);

  // operand select: flops for V0/VF, else memory with same-edge bypass
  always_comb begin
    if (e_r.x == VF_IDX)      opx = vf_r;
    else if (e_r.x == V0_IDX) opx = v0_r;
    else if (xbyp_r)          opx = byp_val_r;
    else if (xvld_r)          opx = xraw_r;
    else                      opx = 8'd0;
    if (e_r.y == VF_IDX)      opy = vf_r;
    else if (e_r.y == V0_IDX) opy = v0_r;
    else if (ybyp_r)          opy = byp_val_r;
    else if (yvld_r)          opy = yraw_r;
    else                      opy = 8'd0;
  end

  always_comb begin
    pc_p2   = pc_r + 12'd2;
    pc_p4   = pc_r + 12'd4;
    sum9    = {1'b0, opx} + {1'b0, opy};
    npc     = pc_p2;
    wr      = 1'b0;
    wflag   = 1'b0;
    flag    = 1'b0;
    clr     = 1'b0;
    push    = 1'b0;
    pop_stk = 1'b0;
    ld_i    = 1'b0;
    val     = 8'd0;
    status  = ST_OK;
    unique case (e_r.cls)
      OP_CLS: clr = 1'b1;
      OP_RET: begin
        if (lvl_r == '0) begin
          status = ST_UNDER;
          npc    = pc_r;
        end else begin
          pop_stk = 1'b1;
          npc     = tos_r;
        end
      end
      OP_JP: npc = e_r.nnn;
      OP_CALL: begin
        if (lvl_r == LVL_FULL) begin
          status = ST_OVER;
          npc    = pc_r;
        end else begin
          push = 1'b1;
          npc  = e_r.nnn;
        end
      end
      OP_SE_K:  if (opx == e_r.nnn[7:0]) npc = pc_p4;
      OP_SNE_K: if (opx != e_r.nnn[7:0]) npc = pc_p4;
      OP_SE_V:  if (opx == opy) npc = pc_p4;
      OP_SNE_V: if (opx != opy) npc = pc_p4;
      OP_LD_K: begin
        wr  = 1'b1;
        val = e_r.nnn[7:0];
      end
      OP_ADD_K: begin
        wr  = 1'b1;
        val = opx + e_r.nnn[7:0];
      end
      OP_ALU: begin
        wr = 1'b1;
        unique case (e_r.fn)
          ALU_LD:  val = opy;
          ALU_OR:  val = opx | opy;
          ALU_AND: val = opx & opy;
          ALU_XOR: val = opx ^ opy;
          ALU_ADD: begin
            val   = sum9[7:0];
            flag  = sum9[8];
            wflag = 1'b1;
          end
          ALU_SUB: begin
            val   = opx - opy;
            flag  = (opx >= opy);
            wflag = 1'b1;
          end
          ALU_SHR: begin
            val   = {1'b0, opy[7:1]};
            flag  = opy[0];
            wflag = 1'b1;
          end
          ALU_SUBN: begin
            val   = opy - opx;
            flag  = (opy >= opx);
            wflag = 1'b1;
          end
          ALU_SHL: begin
            val   = {opy[6:0], 1'b0};
            flag  = opy[7];
            wflag = 1'b1;
          end
          default: begin
            wr     = 1'b0;
            status = ST_ILL;
            npc    = pc_r;
          end
        endcase
      end
      OP_LD_I:  ld_i = 1'b1;
      OP_JP_V0: npc = e_r.nnn + {4'd0, v0_r};
      OP_RND: begin
        wr  = 1'b1;
        val = e_r.rnd_kk;
      end
      default: begin
        status = ST_ILL;
        npc    = pc_r;
      end
    endcase
  end

  always_comb begin
    pc_nxt  = pc_r;
    i_nxt   = i_r;
    v0_nxt  = v0_r;
    vf_nxt  = vf_r;
    lvl_nxt = lvl_r;
    tos_nxt = tos_r;
    if (retire) begin
      pc_nxt = npc;
      if (ld_i) i_nxt = e_r.nnn;
      if (wr && e_r.x == V0_IDX) v0_nxt = val;
      // VF written last: flag wins over a plain write to VF
      if (wflag) vf_nxt = {7'd0, flag};
      else if (wr && e_r.x == VF_IDX) vf_nxt = val;
      if (push) begin
        lvl_nxt = lvl_r + LVW'(1);
        tos_nxt = pc_p2;
      end else if (pop_stk) begin
        lvl_nxt = lvl_r - LVW'(1);
        tos_nxt = below_r;
      end
    end
    if (cfg_load) pc_nxt = cfg_pc;
    rd_addr = SIW'(lvl_nxt - LVW'(2));
  end

  always_comb begin
    e_valid_nxt = e_valid_r;
    if (q_pop) e_valid_nxt = 1'b1;
    else if (retire) e_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (retire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= START_RESET;
      i_r         <= 12'd0;
      v0_r        <= 8'd0;
      vf_r        <= 8'd0;
      lvl_r       <= '0;
      vvld_r      <= 16'd0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      v0_r        <= v0_nxt;
      vf_r        <= vf_nxt;
      lvl_r       <= lvl_nxt;
      e_valid_r   <= e_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (retire && wr) vvld_r[e_r.x] <= 1'b1;
    end
  end

  // register file memory: one write, two registered reads at pop
  always_ff @(posedge clk) begin
    if (retire && wr) vmem[e_r.x] <= val;
    if (q_pop) begin
      xraw_r    <= vmem[q_head.x];
      yraw_r    <= vmem[q_head.y];
      xvld_r    <= vvld_r[q_head.x];
      yvld_r    <= vvld_r[q_head.y];
      xbyp_r    <= retire && wr && (e_r.x == q_head.x);
      ybyp_r    <= retire && wr && (e_r.x == q_head.y);
      byp_val_r <= val;
      e_r       <= q_head;
    end
  end

  // return stack memory; below_r tracks the entry under the top
  always_ff @(posedge clk) begin
    if (retire && push) stk[lvl_r[SIW-1:0]] <= pc_p2;
    below_r <= stk[rd_addr];
    tos_r   <= tos_nxt;
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_r.next_pc       <= npc;
      out_r.index_value   <= ld_i ? e_r.nnn : i_r;
      out_r.reg_written   <= wr;
      out_r.written_reg   <= wr ? e_r.x : 4'd0;
      out_r.written_value <= val;
      out_r.flag_value    <= flag;
      out_r.clear_screen  <= clr;
      out_r.status        <= status;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/chip8_instruction_execute_unit.sv
// Top level of the CHIP-8 instruction execute unit: front, queue, back, APB regs.
// Depends on c8ie_pkg, c8ie_front, c8ie_queue, c8ie_back.
//
//  channel | ports                      | transfer
//  --------+----------------------------+-------------------------------
//  input   | in_valid/in_ready/in_data  | one instruction + random byte
//  result  | out_valid/out_ready/out_d. | one result per instruction
//  config  | cfg_p* (APB, 32-bit data)  | start_address at 0x0
//
// One instruction per cycle sustained while neither side stalls; the queue is written at the
// accepting edge, the operands are registered at queue pop, and out_valid rises when the result reg is loaded.
// The register file read at queue pop and the execute stage set the pace.
// Synchronous active-low reset; PC resets to 0x200, no clearing pass needed.
// Either side may stall; the 2-entry queue and result register absorb it.
module chip8_instruction_execute_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  c8ie_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output c8ie_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import c8ie_pkg::*;

  localparam logic REG_START = 1'b0;

  dec_t        dec, q_head;
  q_stat_t     q_stat;
  logic        push, q_pop;
  logic        cfg_wr;
  logic [11:0] start_r, start_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_START);
  assign start_nxt  = cfg_wr ? cfg_pwdata[11:0] : start_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_START) ? {20'd0, start_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
    end else begin
      start_r <= start_nxt;
    end
  end

  c8ie_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_stat   (q_stat),
    .push     (push),
    .dec      (dec)
  );

  c8ie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (dec),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  c8ie_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .cfg_load  (cfg_wr),
    .cfg_pc    (cfg_pwdata[11:0]),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

`ifndef SYNTHESIS
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.count == 2'd2)
    else $error("input stalled while queue not full");

  a_err_no_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      !out_data.reg_written && !out_data.clear_screen && !out_data.flag_value)
    else $error("faulted transaction reports side effects");

  a_no_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_written |->
      out_data.written_reg == 4'd0 && out_data.written_value == 8'd0)
    else $error("write fields set without register write");
`endif

endmodule

>>> test/tb_chip8_instruction_execute_unit.sv
// Self-checking testbench for chip8_instruction_execute_unit: directed and random
// instruction streams are checked against an in-bench model of the CHIP-8 core state.
// Depends on rtl/c8ie_pkg.sv and the RTL of the unit.
`timescale 1ns / 1ps

module tb_chip8_instruction_execute_unit;
  import c8ie_pkg::*;

  localparam int STACK_LEVELS = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 8;   // extra settle time after the last result
  localparam int LONG_HOLD    = 90;

  localparam logic [2:0] REG_START_ADDR = 3'd0;

  // top nibble of the instruction word
  localparam logic [3:0] NIB_SYS   = 4'h0;
  localparam logic [3:0] NIB_JP    = 4'h1;
  localparam logic [3:0] NIB_CALL  = 4'h2;
  localparam logic [3:0] NIB_SE_K  = 4'h3;
  localparam logic [3:0] NIB_SNE_K = 4'h4;
  localparam logic [3:0] NIB_SE_V  = 4'h5;
  localparam logic [3:0] NIB_LD_K  = 4'h6;
  localparam logic [3:0] NIB_ADD_K = 4'h7;
  localparam logic [3:0] NIB_ALU   = 4'h8;
  localparam logic [3:0] NIB_SNE_V = 4'h9;
  localparam logic [3:0] NIB_LD_I  = 4'hA;
  localparam logic [3:0] NIB_JP_V0 = 4'hB;
  localparam logic [3:0] NIB_RND   = 4'hC;

  localparam logic [15:0] CLS_WORD = 16'h00E0;
  localparam logic [15:0] RET_WORD = 16'h00EE;

  class exec_scoreboard;
    logic [11:0] pc;
    logic [11:0] index_reg;
    logic [7:0]  vreg [16];
    logic [11:0] ret_stack [STACK_LEVELS];
    int unsigned call_depth;
    out_item_t   expected_q [$];
    int unsigned errors;

    function void power_on();
      pc = START_RESET;
      index_reg = '0;
      call_depth = 0;
      errors = 0;
      foreach (vreg[i]) vreg[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
    endfunction

    function void load_start(logic [11:0] addr);
      pc = addr;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // executes one accepted instruction and queues the result it must produce
    function void note_instruction(in_item_t it);
      logic [15:0] op;
      logic [3:0]  x, y, fn;
      logic [7:0]  kk, vx, vy, val;
      logic [11:0] nnn, npc;
      logic [8:0]  sum;
      logic        flag, wr, wflag, clr;
      logic [1:0]  st;
      out_item_t   res;
      op = it.instruction;
      x = op[11:8];
      y = op[7:4];
      fn = op[3:0];
      kk = op[7:0];
      nnn = op[11:0];
      vx = vreg[x];
      vy = vreg[y];
      npc = pc + 12'd2;
      val = '0;
      flag = 1'b0;
      wr = 1'b0;
      wflag = 1'b0;
      clr = 1'b0;
      st = ST_OK;
      case (op[15:12])
        NIB_SYS: begin
          if (op == CLS_WORD) begin
            clr = 1'b1;
          end else if (op == RET_WORD) begin
            if (call_depth == 0) begin
              st = ST_UNDER;
            end else begin
              call_depth--;
              npc = ret_stack[call_depth];
            end
          end else begin
            st = ST_ILL;
          end
        end
        NIB_JP: npc = nnn;
        NIB_CALL: begin
          if (call_depth >= STACK_LEVELS) begin
            st = ST_OVER;
          end else begin
            ret_stack[call_depth] = npc;
            call_depth++;
            npc = nnn;
          end
        end
        NIB_SE_K:  if (vx == kk) npc = pc + 12'd4;
        NIB_SNE_K: if (vx != kk) npc = pc + 12'd4;
        NIB_SE_V: begin
          if (fn != 4'h0) st = ST_ILL;
          else if (vx == vy) npc = pc + 12'd4;
        end
        NIB_SNE_V: begin
          if (fn != 4'h0) st = ST_ILL;
          else if (vx != vy) npc = pc + 12'd4;
        end
        NIB_LD_K: begin
          wr = 1'b1;
          val = kk;
        end
        NIB_ADD_K: begin
          wr = 1'b1;
          val = vx + kk;
        end
        NIB_ALU: begin
          wr = 1'b1;
          case (fn)
            ALU_LD:  val = vy;
            ALU_OR:  val = vx | vy;
            ALU_AND: val = vx & vy;
            ALU_XOR: val = vx ^ vy;
            ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              val = sum[7:0];
              flag = sum[8];
              wflag = 1'b1;
            end
            ALU_SUB: begin
              val = vx - vy;
              flag = (vx >= vy);
              wflag = 1'b1;
            end
            ALU_SHR: begin
              val = {1'b0, vy[7:1]};
              flag = vy[0];
              wflag = 1'b1;
            end
            ALU_SUBN: begin
              val = vy - vx;
              flag = (vy >= vx);
              wflag = 1'b1;
            end
            ALU_SHL: begin
              val = {vy[6:0], 1'b0};
              flag = vy[7];
              wflag = 1'b1;
            end
            default: begin
              wr = 1'b0;
              st = ST_ILL;
            end
          endcase
        end
        NIB_LD_I:  index_reg = nnn;
        NIB_JP_V0: npc = {4'h0, vreg[V0_IDX]} + nnn;
        NIB_RND: begin
          wr = 1'b1;
          val = it.random_byte & kk;
        end
        default: st = ST_ILL;
      endcase
      if (st != ST_OK) begin
        npc = pc;
        wr = 1'b0;
        wflag = 1'b0;
        clr = 1'b0;
        val = '0;
        flag = 1'b0;
      end
      // VF is written after Vx, so a flag op targeting VF leaves the flag there
      if (wr) vreg[x] = val;
      if (wflag) vreg[VF_IDX] = {7'd0, flag};
      pc = npc;
      res.next_pc = npc;
      res.index_value = index_reg;
      res.reg_written = wr;
      res.written_reg = wr ? x : 4'h0;
      res.written_value = wr ? val : 8'h00;
      res.flag_value = wflag ? flag : 1'b0;
      res.clear_screen = clr;
      res.status = st;
      expected_q.push_back(res);
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display({"%0t %s: exp pc=%h I=%h wr=%b x=%h v=%h vf=%b cls=%b st=%0d",
                  " | got pc=%h I=%h wr=%b x=%h v=%h vf=%b cls=%b st=%0d"},
                 $time, what, want.next_pc, want.index_value, want.reg_written,
                 want.written_reg, want.written_value, want.flag_value,
                 want.clear_screen, want.status, got.next_pc, got.index_value,
                 got.reg_written, got.written_reg, got.written_value, got.flag_value,
                 got.clear_screen, got.status);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.next_pc !== want.next_pc || got.index_value !== want.index_value ||
          got.reg_written !== want.reg_written || got.written_reg !== want.written_reg ||
          got.written_value !== want.written_value || got.flag_value !== want.flag_value ||
          got.clear_screen !== want.clear_screen || got.status !== want.status)
        report("mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  exec_scoreboard sb = new;

  bit          calm = 1'b0;      // no idling on either side
  bit          hold_out = 1'b0;  // request a long receiver stall
  int unsigned burst_left = 0;
  bit          burst_call = 1'b0;

  chip8_instruction_execute_unit #(.STACK_DEPTH(STACK_LEVELS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // result side: random stalls plus one long hold when asked
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_instruction(it);
  endtask

  task automatic send_op(logic [15:0] op);
    in_item_t it;
    it.instruction = op;
    it.random_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic pause_input(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender waits for every outstanding transaction, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [11:0] addr);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_START_ADDR;
    cfg_pwdata  <= {20'($urandom), addr};  // upper bits must be ignored
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.load_start(addr);
    @(posedge clk);
  endtask

  // mostly legal instructions, operands biased so skips hit and the stack fills and empties
  function automatic in_item_t pick_instr();
    in_item_t    it;
    logic [3:0]  x, y, fn;
    logic [7:0]  kk;
    logic [11:0] nnn;
    int unsigned sel;
    x = 4'($urandom_range(0, 15));
    y = 4'($urandom_range(0, 15));
    kk = 8'($urandom_range(0, 255));
    nnn = 12'($urandom_range(0, 4095));
    fn = 4'h0;
    it.random_byte = 8'($urandom_range(0, 255));
    if (burst_left == 0 && $urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(4, 20);
      burst_call = 1'($urandom_range(0, 1));
    end
    sel = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      it.instruction = burst_call ? {NIB_CALL, nnn} : RET_WORD;
    end else if (sel < 10) begin
      it.instruction = 16'($urandom_range(0, 65535));
    end else if (sel < 14) begin
      it.instruction = {NIB_CALL, nnn};
    end else if (sel < 18) begin
      it.instruction = RET_WORD;
    end else if (sel < 20) begin
      it.instruction = CLS_WORD;
    end else if (sel < 24) begin
      it.instruction = {NIB_JP, nnn};
    end else if (sel < 28) begin
      it.instruction = {NIB_JP_V0, nnn};
    end else if (sel < 32) begin
      it.instruction = {NIB_LD_I, nnn};
    end else if (sel < 38) begin
      it.instruction = {NIB_LD_K, x, kk};
    end else if (sel < 43) begin
      it.instruction = {NIB_ADD_K, x, kk};
    end else if (sel < 48) begin
      it.instruction = {NIB_RND, x, kk};
    end else if (sel < 56) begin
      if ($urandom_range(0, 1)) kk = sb.vreg[x];
      it.instruction = {($urandom_range(0, 1) ? NIB_SE_K : NIB_SNE_K), x, kk};
    end else if (sel < 64) begin
      if ($urandom_range(0, 1)) y = x;
      if ($urandom_range(0, 6) == 0) fn = 4'($urandom_range(1, 15));
      it.instruction = {($urandom_range(0, 1) ? NIB_SE_V : NIB_SNE_V), x, y, fn};
    end else begin
      case ($urandom_range(0, 9))
        0: fn = ALU_LD;
        1: fn = ALU_OR;
        2: fn = ALU_AND;
        3: fn = ALU_XOR;
        4: fn = ALU_ADD;
        5: fn = ALU_SUB;
        6: fn = ALU_SHR;
        7: fn = ALU_SUBN;
        8: fn = ALU_SHL;
        default: fn = 4'($urandom_range(0, 15));
      endcase
      it.instruction = {NIB_ALU, x, y, fn};
    end
    return it;
  endfunction

  task automatic run_random(int unsigned count, bit gaps);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(pick_instr());
      if (gaps && !calm && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 12));
    end
  endtask

  task automatic run_opening();
    send_op(CLS_WORD);
    send_op(RET_WORD);      // return on empty stack
    send_op(16'h61FF);
    send_op(16'h6201);
    send_op(16'h8124);      // FF + 01: wraps with carry
    send_op(16'h7FFF);      // add immediate into VF
    send_op(16'h6381);
    send_op(16'h8F36);      // shift right into VF: VF keeps the flag
    send_op(16'h843E);
    send_op(16'h8425);
    send_op(16'h8347);      // reverse subtract with borrow
    send_op(16'h8531);
    send_op(16'h8632);
    send_op(16'h8733);
    send_op(16'h8830);
    send_op(16'h8128);      // undefined ALU function
    send_op(16'h3380);
    send_op(16'h4380);
    send_op(16'h5330);
    send_op(16'h9340);
    send_op(16'h5341);      // register skip with nonzero low nibble
    send_op(16'hAFFF);
    send_op(16'hC5FF);
    send_op(16'h2ABC);
    send_op(RET_WORD);
    send_op(16'h60FF);
    send_op(16'hBFFF);      // V0 + NNN wraps past 0xFFF
    send_op(16'h0123);
    send_op(16'hF00A);
  endtask

  initial begin
    sb.power_on();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_opening();
    drain();

    cfg_write(12'hFFE);
    run_random(320, 1'b1);
    drain();

    // block fills while results are held back
    hold_out = 1'b1;
    run_random(40, 1'b0);
    drain();

    cfg_write(12'h000);
    run_random(320, 1'b1);
    drain();

    cfg_write(12'hFFF);
    run_random(320, 1'b1);
    drain();

    cfg_write(12'($urandom_range(0, 4095)));
    run_random(260, 1'b1);
    calm = 1'b1;
    run_random(320, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[chip8_instruction_execute_unit] OK");
    end else begin
      $display("[chip8_instruction_execute_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[chip8_instruction_execute_unit] ERROR");
    $finish;
  end

endmodule
